// File: rtl/core/mm2_pkg.sv
// Shared types and constants of the MurmurHash2 byte stream hash.
package mm2_pkg;

	localparam logic [31:0] MurmurMul     = 32'h5bd1e995;
	localparam logic [31:0] SeedReset     = 32'd42;
	localparam int          QueueDepthDef = 4;

	// Work handed from the front to the back for one item.
	typedef struct packed {
		logic        seed_vld;
		logic [31:0] seed;
		logic        word_vld;
		logic [31:0] word;
		logic        fin_vld;
		logic [23:0] tail;
		logic        tail_vld;
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_K1,
		ST_K2,
		ST_H,
		ST_TAIL,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

// File: rtl/core/mm2_front.sv
// Front end: seed register, byte gathering and op classification.
module mm2_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [31:0]       cfg_data,
	input  logic              in_acc,
	input  logic [7:0]        byte_value,
	input  logic [31:0]       message_length,
	input  logic              first_item,
	input  logic              last_item,
	input  logic              carries_byte,
	output logic              push,
	output mm2_pkg::op_t      op
);
	import mm2_pkg::*;

	logic [31:0] seed_q;
	logic [23:0] pend_q;
	logic [1:0]  pos_q;
	logic [23:0] pend0, pend1;
	logic [1:0]  pos0, pos1;
	logic        word_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SeedReset;
		end else if (cfg_valid) begin
			seed_q <= cfg_data;
		end
	end

	always_comb begin
		pos0     = first_item ? 2'd0 : pos_q;
		pend0    = first_item ? 24'd0 : pend_q;
		pos1     = pos0;
		pend1    = pend0;
		word_vld = 1'b0;
		if (carries_byte) begin
			if (pos0 == 2'd3) begin
				word_vld = 1'b1;
				pos1     = 2'd0;
				pend1    = 24'd0;
			end else begin
				pend1 = pend0 | (24'(byte_value) << {pos0, 3'b000});
				pos1  = 2'(pos0 + 2'd1);
			end
		end
		op.seed_vld = first_item;
		op.seed     = seed_q ^ message_length;
		op.word_vld = word_vld;
		op.word     = {byte_value, pend0};
		op.fin_vld  = last_item;
		op.tail     = pend1;
		op.tail_vld = (pos1 != 2'd0);
		push        = in_acc && (first_item || word_vld || last_item);
	end

	// Drop the gathered bytes once the message is finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 2'd0;
			pend_q <= 24'd0;
		end else if (in_acc) begin
			pos_q  <= last_item ? 2'd0 : pos1;
			pend_q <= last_item ? 24'd0 : pend1;
		end
	end

endmodule

// File: rtl/core/mm2_queue.sv
// Short op queue between front and back.
module mm2_queue #(
	parameter int DEPTH = mm2_pkg::QueueDepthDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  mm2_pkg::op_t wr_op,
	output logic         full,
	input  logic         pop,
	output logic         rd_vld,
	output mm2_pkg::op_t rd_op
);
	import mm2_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	op_t             mem_q [DEPTH];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;

	assign full   = (cnt_q == CntW'(DEPTH));
	assign rd_vld = (cnt_q != '0);
	assign rd_op  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_q + 1'b1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= CntW'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CntW'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> rd_vld)
		else $error("queue read while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(DEPTH))
		else $error("queue count out of range");

endmodule

// File: rtl/core/mm2_back.sv
// Back end: word mixing, tail fold and final avalanche on one shared multiplier.
module mm2_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         op_vld,
	input  mm2_pkg::op_t op,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [31:0]  out_data
);
	import mm2_pkg::*;

	state_t      state_q, state_d;
	logic [31:0] h_q, k_q, mul_in, prod, out_q;
	logic        fin_q, tail_vld_q, out_valid_q, load_out;
	logic [23:0] tail_q;

	assign prod = 32'(mul_in * MurmurMul);

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		mul_in   = h_q;
		unique case (state_q)
			ST_IDLE: begin
				if (op_vld) begin
					pop = 1'b1;
					if (op.word_vld) begin
						state_d = ST_K1;
					end else if (op.fin_vld) begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_K1: begin
				mul_in  = k_q;
				state_d = ST_K2;
			end
			ST_K2: begin
				mul_in  = k_q ^ (k_q >> 24);
				state_d = ST_H;
			end
			ST_H: begin
				mul_in  = h_q;
				state_d = fin_q ? ST_TAIL : ST_IDLE;
			end
			ST_TAIL: begin
				mul_in  = h_q ^ {8'd0, tail_q};
				state_d = ST_FIN;
			end
			ST_FIN: begin
				mul_in  = h_q ^ (h_q >> 13);
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q         <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (pop && op.seed_vld) h_q <= op.seed;
				ST_H:    h_q <= prod ^ k_q;
				ST_TAIL: if (tail_vld_q) h_q <= prod;
				ST_FIN:  h_q <= prod;
				ST_OUT:  if (load_out) h_q <= 32'd0;
				default: h_q <= h_q;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			k_q        <= op.word;
			fin_q      <= op.fin_vld;
			tail_q     <= op.tail;
			tail_vld_q <= op.tail_vld;
		end else if (state_q == ST_K1 || state_q == ST_K2) begin
			k_q <= prod;
		end
		if (load_out) begin
			out_q <= h_q ^ (h_q >> 15);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside output step");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_IDLE)
		else $error("op taken while busy");
	a_hash_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> h_q == 32'd0)
		else $error("running hash not cleared after result");

endmodule

// File: rtl/core/murmur2_byte_stream_hash.sv
// Top level of the MurmurHash2 byte stream hash.
// Computes 32-bit MurmurHash2 over a byte stream, one byte per input word. The
// front takes a word every cycle while the op queue has room; a word that
// only adds a byte to the pending group costs nothing further, and a first
// word that completes no group costs a dispatch step in the back. A word
// that completes a 32-bit group costs the back a dispatch step, two key
// multiplies and one hash multiply. A last word adds a tail fold, an
// avalanche multiply and a result load, plus a dispatch step when it
// completes no group, and the result load waits while the previous result is
// not taken on m_axis_tready; all multiplies share one 32x32 multiplier. A
// steady byte stream thus runs at one byte per cycle while the op queue is
// not full, the queue absorbing the word mixes. The result sits in an output
// register so the next message proceeds while it waits. The seed register
// (reset 42) is written through the cfg channel, which is always ready.
module murmur2_byte_stream_hash #(
	parameter int QUEUE_DEPTH = mm2_pkg::QueueDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // byte_value[7:0], message_length[39:8]
	input  logic [1:0]  s_axis_tuser,  // first_item[0], carries_byte[1]
	input  logic        s_axis_tlast,  // last_item
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // hash_value[31:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data       // hash_seed
);
	import mm2_pkg::*;

	logic full, push, in_acc, q_vld, pop;
	op_t  wr_op, rd_op;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !full;
	assign in_acc        = s_axis_tvalid && !full;

	mm2_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.in_acc         (in_acc),
		.byte_value     (s_axis_tdata[7:0]),
		.message_length (s_axis_tdata[39:8]),
		.first_item     (s_axis_tuser[0]),
		.last_item      (s_axis_tlast),
		.carries_byte   (s_axis_tuser[1]),
		.push           (push),
		.op             (wr_op)
	);

	mm2_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_op  (wr_op),
		.full   (full),
		.pop    (pop),
		.rd_vld (q_vld),
		.rd_op  (rd_op)
	);

	mm2_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_vld    (q_vld),
		.op        (rd_op),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
